FILE: src/graphic_queue_batch_framer_core_macros.svh
// assertion helpers shared by the framer
`ifndef GRAPHIC_QUEUE_BATCH_FRAMER_CORE_MACROS_SVH
`define GRAPHIC_QUEUE_BATCH_FRAMER_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define GQBF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, off while reset is high
`define GQBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: src/gqbf_pkg.sv
package gqbf_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   // input word: 24+3+3+4+4+9+9+64+32+1 = 153 bits, padded to bytes
   localparam int REQ_W = 160;
   // result word without the queue level field
   localparam int RSP_FIXED_W = 177;
   // bit offset of the queue level inside the result word
   localparam int LVL_OFS = 145;
   // queue entry: geometry, tag, control word
   localparam int ENTRY_W = 120;
   localparam int CSR_IDX_W = 8;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLED      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SENDER_ID    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECEIVER_ID  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INTERVAL = 8'd3;

   localparam logic [2:0] OP_MAX    = 3'd3;
   localparam logic [2:0] TYPE_TEXT = 3'd7;
   localparam logic [3:0] LAYER_MAX = 4'd9;
   localparam logic [3:0] COLOR_MAX = 4'd8;

   localparam logic [2:0] BATCH_1 = 3'd1;
   localparam logic [2:0] BATCH_2 = 3'd2;
   localparam logic [2:0] BATCH_5 = 3'd5;
   localparam logic [2:0] BATCH_7 = 3'd7;

   localparam logic [15:0] FRAME_CMD_1 = 16'h0101;
   localparam logic [15:0] FRAME_CMD_2 = 16'h0102;
   localparam logic [15:0] FRAME_CMD_5 = 16'h0103;
   localparam logic [15:0] FRAME_CMD_7 = 16'h0104;

   localparam logic [6:0] FRAME_LEN_1 = 7'(6 + 15 * 1);
   localparam logic [6:0] FRAME_LEN_2 = 7'(6 + 15 * 2);
   localparam logic [6:0] FRAME_LEN_5 = 7'(6 + 15 * 5);
   localparam logic [6:0] FRAME_LEN_7 = 7'(6 + 15 * 7);

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_RECORD = 2'd2
   } gqbf_kind_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_FULL     = 2'd2
   } gqbf_status_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic enq_commit;
      logic tick_eval;
      logic load_hdr;
      logic load_rec;
   } gqbf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_tick;
      logic out_free;
      logic send_go;
      logic rec_last;
   } gqbf_status_type_s_type;

endpackage

FILE: src/gqbf_ram.sv
module gqbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/gqbf_ctrl.sv
module gqbf_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  gqbf_pkg::gqbf_status_type_s_type st,
   output gqbf_pkg::gqbf_cmd_type          cmd
);

   import gqbf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_TICK = 5'b00100,
      ST_HDR  = 5'b01000,
      ST_REC  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = st.req_tick ? ST_TICK : ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (st.out_free) begin
               cmd.enq_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_TICK: begin
            cmd.tick_eval = 1'b1;
            state_in      = st.send_go ? ST_HDR : ST_IDLE;
         end
         ST_HDR: begin
            if (st.out_free) begin
               cmd.load_hdr = 1'b1;
               state_in     = ST_REC;
            end
         end
         ST_REC: begin
            if (st.out_free) begin
               cmd.load_rec = 1'b1;
               if (st.rec_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

FILE: src/gqbf_dp.sv
module gqbf_dp #(
   parameter int QUEUE_DEPTH = gqbf_pkg::QUEUE_DEPTH_DEF,
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((gqbf_pkg::RSP_FIXED_W + LVL_W + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gqbf_pkg::gqbf_cmd_type               cmd,
   output gqbf_pkg::gqbf_status_type_s_type     st,
   input  logic [gqbf_pkg::REQ_W-1:0]           req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_W-1:0]                     rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gqbf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                          csr_data
);

   import gqbf_pkg::*;

   localparam int PW       = $clog2(QUEUE_DEPTH);
   localparam int RSP_USED = RSP_FIXED_W + LVL_W;

   // configuration
   logic        enabled_ff;
   logic [15:0] sender_ff;
   logic [15:0] receiver_ff;
   logic [31:0] min_ff;

   // latched input item
   logic [23:0] in_tag_ff;
   logic [2:0]  in_op_ff;
   logic [2:0]  in_typ_ff;
   logic [3:0]  in_layer_ff;
   logic [3:0]  in_color_ff;
   logic [8:0]  in_sa_ff;
   logic [8:0]  in_ea_ff;
   logic [63:0] in_geom_ff;
   logic [31:0] in_el_ff;
   logic        in_busy_ff;

   // queue and timing state
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [LVL_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      drop_ff, drop_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [2:0]       left_ff, left_in;
   logic [15:0]      fcmd_ff, fcmd_in;
   logic [6:0]       flen_ff, flen_in;

   // output register
   logic            out_valid_ff, out_valid_in;
   gqbf_kind_type   out_kind_ff, out_kind_in;
   gqbf_status_type out_status_ff, out_status_in;
   logic [15:0]     out_cmd_ff, out_cmd_in;
   logic [6:0]      out_len_ff, out_len_in;
   logic [23:0]     out_tag_ff, out_tag_in;
   logic [31:0]     out_ctrl_ff, out_ctrl_in;
   logic [31:0]     out_sw_ff, out_sw_in;
   logic [31:0]     out_ew_ff, out_ew_in;
   logic            out_last_ff, out_last_in;
   logic [LVL_W-1:0] out_lvl_ff;
   logic [31:0]     out_drop_ff;

   logic                 desc_ok;
   logic                 q_full;
   logic [31:0]          ctrl_word;
   logic [32:0]          acc_sum;
   logic [31:0]          acc_sat;
   logic                 send_go;
   logic [2:0]           batch;
   logic [15:0]          batch_cmd;
   logic [6:0]           batch_len;
   logic [PW:0]          head_sum;
   logic [PW-1:0]        head_step;
   logic [PW-1:0]        tail_step;
   logic [PW-1:0]        rptr_step;
   logic                 rec_last;
   logic                 out_load;
   gqbf_status_type      enq_status;
   logic                 ram_we;
   logic [PW-1:0]        ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;

   // configuration writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         sender_ff   <= 16'd1;
         receiver_ff <= 16'd1;
         min_ff      <= 32'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLED:      enabled_ff  <= csr_data[0];
            REG_SENDER_ID:    sender_ff   <= csr_data[15:0];
            REG_RECEIVER_ID:  receiver_ff <= csr_data[15:0];
            REG_MIN_INTERVAL: min_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         in_tag_ff   <= req_tdata[23:0];
         in_op_ff    <= req_tdata[26:24];
         in_typ_ff   <= req_tdata[29:27];
         in_layer_ff <= req_tdata[33:30];
         in_color_ff <= req_tdata[37:34];
         in_sa_ff    <= req_tdata[46:38];
         in_ea_ff    <= req_tdata[55:47];
         in_geom_ff  <= req_tdata[119:56];
         in_el_ff    <= req_tdata[151:120];
         in_busy_ff  <= req_tdata[152];
      end
   end

   assign desc_ok = (in_op_ff <= OP_MAX) && (in_typ_ff != TYPE_TEXT) &&
                    (in_layer_ff <= LAYER_MAX) && (in_color_ff <= COLOR_MAX);
   assign q_full    = (cnt_ff == LVL_W'(QUEUE_DEPTH));
   assign ctrl_word = {in_ea_ff, in_sa_ff, in_color_ff, in_layer_ff, in_typ_ff, in_op_ff};

   assign acc_sum = {1'b0, acc_ff} + {1'b0, in_el_ff};
   assign acc_sat = acc_sum[32] ? '1 : acc_sum[31:0];
   assign send_go = enabled_ff && (cnt_ff != '0) && (acc_sat >= min_ff) && !in_busy_ff;

   always_comb begin
      priority if (cnt_ff >= LVL_W'(BATCH_7)) begin
         batch = BATCH_7; batch_cmd = FRAME_CMD_7; batch_len = FRAME_LEN_7;
      end else if (cnt_ff >= LVL_W'(BATCH_5)) begin
         batch = BATCH_5; batch_cmd = FRAME_CMD_5; batch_len = FRAME_LEN_5;
      end else if (cnt_ff >= LVL_W'(BATCH_2)) begin
         batch = BATCH_2; batch_cmd = FRAME_CMD_2; batch_len = FRAME_LEN_2;
      end else begin
         batch = BATCH_1; batch_cmd = FRAME_CMD_1; batch_len = FRAME_LEN_1;
      end
   end

   // ring pointer arithmetic, depth need not be a power of two
   assign head_sum  = {1'b0, head_ff} + (PW + 1)'(batch);
   assign head_step = (head_sum >= (PW + 1)'(QUEUE_DEPTH)) ?
                      PW'(head_sum - (PW + 1)'(QUEUE_DEPTH)) : head_sum[PW-1:0];
   assign tail_step = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PW'(1);
   assign rptr_step = (rptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
   assign rec_last  = (left_ff == 3'd1);

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      drop_in    = drop_ff;
      rptr_in    = rptr_ff;
      left_in    = left_ff;
      fcmd_in    = fcmd_ff;
      flen_in    = flen_ff;
      ram_we     = 1'b0;
      enq_status = STATUS_INVALID;
      if (cmd.enq_commit) begin
         priority if (!desc_ok) begin
            enq_status = STATUS_INVALID;
         end else if (q_full) begin
            drop_in    = drop_ff + 32'd1;
            enq_status = STATUS_FULL;
         end else begin
            ram_we     = 1'b1;
            tail_in    = tail_step;
            cnt_in     = cnt_ff + LVL_W'(1);
            enq_status = STATUS_ACCEPTED;
         end
      end
      if (cmd.tick_eval) begin
         acc_in = acc_sat;
         if (send_go) begin
            acc_in  = '0;
            head_in = head_step;
            cnt_in  = cnt_ff - LVL_W'(batch);
            rptr_in = head_ff;
            left_in = batch;
            fcmd_in = batch_cmd;
            flen_in = batch_len;
         end
      end
      if (cmd.load_rec) begin
         rptr_in = rptr_step;
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
         acc_ff  <= '1;
         drop_ff <= '0;
         left_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         drop_ff <= drop_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff <= rptr_in;
      fcmd_ff <= fcmd_in;
      flen_ff <= flen_in;
   end

   // read one slot ahead so the record data is ready each cycle
   assign ram_raddr = (cmd.tick_eval && send_go) ? head_ff :
                      (cmd.load_rec ? rptr_step : rptr_ff);

   gqbf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata ({in_geom_ff, in_tag_ff, ctrl_word}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // output register
   assign out_load     = cmd.enq_commit || cmd.load_hdr || cmd.load_rec;
   assign out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_comb begin
      out_kind_in   = KIND_STATUS;
      out_status_in = STATUS_ACCEPTED;
      out_cmd_in    = '0;
      out_len_in    = '0;
      out_tag_in    = '0;
      out_ctrl_in   = '0;
      out_sw_in     = '0;
      out_ew_in     = '0;
      out_last_in   = 1'b0;
      priority if (cmd.enq_commit) begin
         out_kind_in   = KIND_STATUS;
         out_status_in = enq_status;
         out_last_in   = 1'b1;
      end else if (cmd.load_hdr) begin
         out_kind_in = KIND_HEADER;
         out_cmd_in  = fcmd_ff;
         out_len_in  = flen_ff;
         out_sw_in   = {16'd0, sender_ff};
         out_ew_in   = {16'd0, receiver_ff};
      end else begin
         out_kind_in = KIND_RECORD;
         out_ctrl_in = ram_rdata[31:0];
         out_tag_in  = ram_rdata[55:32];
         out_sw_in   = ram_rdata[87:56];
         out_ew_in   = ram_rdata[119:88];
         out_last_in = rec_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_status_ff <= out_status_in;
         out_cmd_ff    <= out_cmd_in;
         out_len_ff    <= out_len_in;
         out_tag_ff    <= out_tag_in;
         out_ctrl_ff   <= out_ctrl_in;
         out_sw_ff     <= out_sw_in;
         out_ew_ff     <= out_ew_in;
         out_last_ff   <= out_last_in;
         out_lvl_ff    <= cnt_in;
         out_drop_ff   <= drop_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_USED-1:0] = {out_drop_ff, out_lvl_ff, out_ew_ff, out_sw_ff,
                                 out_ctrl_ff, out_tag_ff, out_len_ff, out_cmd_ff,
                                 out_status_ff};
   end

   assign st.req_tick = (req_tuser == CMD_TICK);
   assign st.out_free = !out_valid_ff || rsp_tready;
   assign st.send_go  = send_go;
   assign st.rec_last = rec_last;

endmodule

FILE: src/graphic_queue_batch_framer_core.sv
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata, req_tuser (command)
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser (kind), rsp_tlast
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// one item in flight; an enqueue or a quiet tick steps through accept and
// evaluate, a sending tick through accept, evaluate, header, then one record
// per cycle while rsp is free, out of the queue ram's single read port
// synchronous active-high reset clears control, counters and the output valid;
// queue storage is not cleared, only written slots are ever read
// req is taken while a result word waits; a stalled rsp side holds the sequencer
`include "graphic_queue_batch_framer_core_macros.svh"

module graphic_queue_batch_framer_core #(
   parameter int QUEUE_DEPTH = gqbf_pkg::QUEUE_DEPTH_DEF,
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((gqbf_pkg::RSP_FIXED_W + LVL_W + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   // graphic_tag, operation, shape_type, layer, color, sweep_from, sweep_to,
   // geometry, elapsed_ms, link_busy, zero pad
   input  logic [gqbf_pkg::REQ_W-1:0]     req_tdata,
   // command
   input  logic                           req_tuser,

   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status, frame_cmd, frame_length, record_tag, record_ctrl, record_start,
   // record_end, queue_level, dropped_count, zero pad
   output logic [RSP_W-1:0]               rsp_tdata,
   // kind
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gqbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);

   import gqbf_pkg::*;

   // sequencer commands and datapath status
   gqbf_cmd_type            ctrl_cmd;
   gqbf_status_type_s_type  dp_st;

   // observation terms for the checks below
   logic hdr_taken;
   logic rec_shown;
   logic enq_ok_shown;
   logic level_nonzero;
   logic seq_load;

   // sequencer: accept, evaluate, header, records
   gqbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (dp_st),
      .cmd        (ctrl_cmd)
   );

   // registers, queue ram, accumulator, output stage
   gqbf_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .st         (dp_st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   assign hdr_taken     = rsp_tvalid && rsp_tready && (rsp_tuser == KIND_HEADER);
   assign rec_shown     = rsp_tvalid && (rsp_tuser == KIND_RECORD);
   assign enq_ok_shown  = rsp_tvalid && (rsp_tuser == KIND_STATUS) &&
                          (rsp_tdata[1:0] == STATUS_ACCEPTED);
   assign level_nonzero = (rsp_tdata[LVL_OFS +: LVL_W] != '0);
   assign seq_load      = ctrl_cmd.enq_commit || ctrl_cmd.load_hdr || ctrl_cmd.load_rec;

   // a taken header is always followed at once by a record
   `GQBF_ASSERT_NEXT(a_hdr_then_rec, clock, reset, hdr_taken, rec_shown)

   // an accepted graphic leaves the queue non-empty
   `GQBF_ASSERT_IMPLY(a_accept_level, clock, reset, enq_ok_shown, level_nonzero)

   // the sequencer never loads a word over one still waiting
   `GQBF_ASSERT_IMPLY(a_load_free, clock, reset, seq_load, dp_st.out_free)

endmodule
